FILE: design/vtmux_pkg.sv
// ----------------------------------------------------------------------------
// Virtual timer multiplexer package
// Result kinds, status codes, field widths and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package vtmux_pkg;

  localparam int DATA_W = 32;
  localparam int TAG_W  = 8;
  localparam int IN_W   = 72;
  localparam int OUT_W  = 48;

  localparam logic [1:0] KIND_ARM    = 2'd0;
  localparam logic [1:0] KIND_EXPIRE = 2'd1;
  localparam logic [1:0] KIND_REARM  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  typedef struct packed {
    logic load_item;
    logic adv;
    logic expire;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last_slot;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: design/vtmux_ctrl.sv
// ----------------------------------------------------------------------------
// Virtual timer multiplexer controller
// Sequences one item: capture, a scan over all slots, then the closing result.
// ----------------------------------------------------------------------------
`default_nettype none

module vtmux_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  vtmux_pkg::stat_t     stat,
  output vtmux_pkg::cmd_t      cmd
);
  import vtmux_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          if (stat.out_free) begin
            cmd.expire = 1'b1;
            cmd.adv    = 1'b1;
          end
        end else begin
          cmd.adv = 1'b1;
        end
        if (cmd.adv && stat.last_slot) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/vtmux_dpath.sv
// ----------------------------------------------------------------------------
// Virtual timer multiplexer datapath
// Slot memory, live bits, minimum search, free slot search and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtmux_dpath #(
  parameter int SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  vtmux_pkg::cmd_t                 cmd,
  output vtmux_pkg::stat_t                stat,
  input  wire logic [vtmux_pkg::IN_W-1:0] s_tdata,
  input  wire logic                       s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [vtmux_pkg::OUT_W-1:0]     m_tdata,
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast
);
  import vtmux_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW = DATA_W + TAG_W;

  logic [SLOTS-1:0]  live;
  logic [MW-1:0]     mem [SLOTS];
  logic [MW-1:0]     rd_data;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     free_idx;
  logic              free_found;
  logic              fire;
  logic [DATA_W-1:0] now;
  logic [DATA_W-1:0] dur;
  logic [TAG_W-1:0]  tag;
  logic [DATA_W-1:0] best;
  logic              any;
  logic              hw_running;

  logic [DATA_W-1:0] rd_expiry;
  logic [TAG_W-1:0]  rd_tag;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] min_val;
  logic              min_nz;
  logic              hit;

  logic [1:0]        out_kind;
  logic [1:0]        out_status;
  logic [TAG_W-1:0]  out_tag;
  logic              out_start;
  logic [DATA_W-1:0] out_load;

  logic [1:0]        fin_kind;
  logic [1:0]        fin_status;
  logic              fin_start;

  assign rd_expiry = rd_data[MW-1:TAG_W];
  assign rd_tag    = rd_data[TAG_W-1:0];
  assign rem       = rd_expiry - now;
  assign min_val   = any ? best : '0;
  assign min_nz    = (min_val != '0);
  assign hit       = live[idx] && fire && (rd_expiry <= now);

  assign stat.hit       = hit;
  assign stat.last_slot = (idx == IW'(SLOTS - 1));
  assign stat.out_free  = !m_tvalid || m_tready;

  always_comb begin
    if (cmd.load_item) begin
      rd_addr = '0;
    end else if (cmd.adv && !stat.last_slot) begin
      rd_addr = idx + IW'(1);
    end else begin
      rd_addr = idx;
    end
  end

  always_comb begin
    if (fire) begin
      fin_kind   = KIND_REARM;
      fin_status = STAT_OK;
      fin_start  = min_nz;
    end else begin
      fin_kind = KIND_ARM;
      if (!free_found) begin
        fin_status = STAT_FULL;
        fin_start  = 1'b0;
      end else if (!min_nz) begin
        fin_status = STAT_ZERO;
        fin_start  = 1'b0;
      end else begin
        fin_status = STAT_OK;
        fin_start  = !hw_running;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !fire && free_found) begin
      mem[free_idx] <= {now + dur, tag};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      hw_running <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.expire || cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load_item && s_tuser) begin
        hw_running <= 1'b0;
      end
      if (cmd.expire) begin
        live[idx] <= 1'b0;
      end
      if (cmd.finish) begin
        if (fire) begin
          hw_running <= min_nz;
        end else if (free_found) begin
          live[free_idx] <= 1'b1;
          if (fin_start) begin
            hw_running <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      fire       <= s_tuser;
      now        <= s_tdata[31:0];
      dur        <= s_tdata[63:32];
      tag        <= s_tdata[71:64];
      idx        <= '0;
      best       <= s_tuser ? '1 : s_tdata[63:32];
      any        <= !s_tuser;
      free_found <= 1'b0;
      free_idx   <= '0;
    end
    if (cmd.adv) begin
      if (!stat.last_slot) begin
        idx <= idx + IW'(1);
      end
      if (live[idx] && !hit && (!any || (rem < best))) begin
        best <= rem;
        any  <= 1'b1;
      end
      if (!live[idx] && !fire && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
    end
    if (cmd.expire) begin
      out_kind   <= KIND_EXPIRE;
      out_status <= STAT_OK;
      out_tag    <= rd_tag;
      out_start  <= 1'b0;
      out_load   <= '0;
      m_tlast    <= 1'b0;
    end
    if (cmd.finish) begin
      out_kind   <= fin_kind;
      out_status <= fin_status;
      out_tag    <= '0;
      out_start  <= fin_start;
      out_load   <= fin_start ? min_val : '0;
      m_tlast    <= 1'b1;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {5'd0, out_load, out_start, out_tag, out_status};

endmodule

`default_nettype wire

FILE: design/virtual_timer_multiplexer_unit.sv
// ----------------------------------------------------------------------------
// Virtual timer multiplexer
// Shares one hardware timer among SLOTS virtual timers.
// ----------------------------------------------------------------------------
// Each item passes from its transfer to its closing result through a capture
// step, a scan of every slot through the slot memory's single read port, and
// the closing result. An expiry report that finds the output register still
// holding an untaken result holds the scan until the register is free, and
// the closing result waits the same way. A new item is taken once the closing
// result of the previous one is in the output register.
`default_nettype none

module virtual_timer_multiplexer_unit #(
  parameter int SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // current_tick [31:0], duration [63:32], client_tag [71:64]
  input  wire logic [vtmux_pkg::IN_W-1:0] s_tdata,
  // action [0]
  input  wire logic                       s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // status [1:0], expired_tag [9:2], start_hw [10], hw_load [42:11], zero [47:43]
  output logic [vtmux_pkg::OUT_W-1:0]     m_tdata,
  // kind [1:0]
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast
);
  import vtmux_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  vtmux_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vtmux_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

FILE: design/vtmux_checker.sv
// ----------------------------------------------------------------------------
// Virtual timer multiplexer checker
// Port-level properties of the input handshake and the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vtmux_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [vtmux_pkg::OUT_W-1:0] m_tdata,
  input wire logic [1:0]                 m_tuser,
  input wire logic                       m_tlast
);
  import vtmux_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is at work");

  a_expire_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_EXPIRE) |-> !m_tlast)
    else $error("expiry report marked as last");

  a_arm_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ARM) |-> m_tlast)
    else $error("arm status not marked as last");

  a_load_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> (m_tdata[42:11] != '0))
    else $error("hardware start with zero load");

endmodule

bind virtual_timer_multiplexer_unit vtmux_checker u_vtmux_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
